>>> src/bprt_pkg.sv
// ----------------------------------------------------------------------------
// bprt_pkg
// Shared widths, register indexes and the divider cell word.
// ----------------------------------------------------------------------------
`default_nettype none

package bprt_pkg;

    localparam int COEF_W  = 24;
    localparam int TRIG_W  = 18;
    localparam int POW_W   = 53;
    localparam int GAIN_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int NCELLS  = GAIN_W;
    localparam int IDX_W   = 3;

    localparam logic [COEF_W-1:0] COEF_ONE = 24'h100000;

    typedef enum logic [IDX_W-1:0] {
        REG_NUM_C0 = 3'd0,
        REG_NUM_C1 = 3'd1,
        REG_NUM_C2 = 3'd2,
        REG_DEN_C0 = 3'd3,
        REG_DEN_C1 = 3'd4,
        REG_DEN_C2 = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic              valid;
        logic [POW_W-1:0]  rem;
        logic [POW_W-1:0]  den;
        logic [GAIN_W-1:0] word;
        logic              sat;
        logic              dz;
    } t_cell;

endpackage

`default_nettype wire

>>> src/bprt_poly.sv
// ----------------------------------------------------------------------------
// bprt_poly
// Four-stage power of c0*z^2 + c1*z + c2 on the unit circle point.
// ----------------------------------------------------------------------------
`default_nettype none

module bprt_poly (
    input  wire                                 i_clk,
    input  wire                                 i_en,
    input  wire  signed [bprt_pkg::COEF_W-1:0]  i_c0,
    input  wire  signed [bprt_pkg::COEF_W-1:0]  i_c1,
    input  wire  signed [bprt_pkg::COEF_W-1:0]  i_c2,
    input  wire  signed [bprt_pkg::TRIG_W-1:0]  i_cos_w,
    input  wire  signed [bprt_pkg::TRIG_W-1:0]  i_sin_w,
    input  wire  signed [bprt_pkg::TRIG_W-1:0]  i_cos_2w,
    input  wire  signed [bprt_pkg::TRIG_W-1:0]  i_sin_2w,
    output logic        [bprt_pkg::POW_W-1:0]   o_power
);

    localparam int PW = bprt_pkg::COEF_W + bprt_pkg::TRIG_W;
    localparam int SW = PW + 2;
    localparam int FW = SW - bprt_pkg::FRAC_W;
    localparam int QW = 2 * FW;

    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [bprt_pkg::COEF_W-1:0] r_c2;
    logic signed [FW-1:0] r_re, r_im;
    logic signed [QW-1:0] r_re2, r_im2;
    logic [bprt_pkg::POW_W-1:0] r_pow;

    logic signed [SW-1:0] n_re_sum, n_im_sum;
    logic signed [QW-1:0] n_re2, n_im2;
    logic signed [QW-1:0] n_pow;

    always_comb begin
        n_re_sum = SW'(r_p0) + SW'(r_p1)
                 + (SW'(r_c2) <<< bprt_pkg::FRAC_W);
        n_im_sum = SW'(r_p2) + SW'(r_p3);
        n_re2    = QW'(r_re) * QW'(r_re);
        n_im2    = QW'(r_im) * QW'(r_im);
        n_pow    = r_re2 + r_im2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0  <= PW'(i_c0) * PW'(i_cos_2w);
            r_p1  <= PW'(i_c1) * PW'(i_cos_w);
            r_p2  <= PW'(i_c0) * PW'(i_sin_2w);
            r_p3  <= PW'(i_c1) * PW'(i_sin_w);
            r_c2  <= i_c2;
            r_re  <= FW'(n_re_sum >>> bprt_pkg::FRAC_W);
            r_im  <= FW'(n_im_sum >>> bprt_pkg::FRAC_W);
            r_re2 <= n_re2;
            r_im2 <= n_im2;
            r_pow <= n_pow[bprt_pkg::POW_W-1:0];
        end
    end

    assign o_power = r_pow;

endmodule

`default_nettype wire

>>> src/bprt_div_cell.sv
// ----------------------------------------------------------------------------
// bprt_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bprt_div_cell (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire  bprt_pkg::t_cell   i_cell,
    output bprt_pkg::t_cell         o_cell
);

    bprt_pkg::t_cell r_cell, n_cell;
    logic [bprt_pkg::POW_W:0] n_trial;
    logic [bprt_pkg::POW_W:0] n_diff;
    logic                     n_ge;

    always_comb begin
        n_trial = {i_cell.rem, i_cell.word[bprt_pkg::GAIN_W-1]};
        n_diff  = n_trial - {1'b0, i_cell.den};
        n_ge    = n_trial >= {1'b0, i_cell.den};
        n_cell      = i_cell;
        n_cell.rem  = n_ge ? n_diff[bprt_pkg::POW_W-1:0] : n_trial[bprt_pkg::POW_W-1:0];
        n_cell.word = {i_cell.word[bprt_pkg::GAIN_W-2:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

>>> src/biquad_power_response_trig_supplied_top.sv
// Pipeline: 4 product/power stages, one setup stage, 32 divider cells and one
// output register between input word and output word.
// Throughput: one word per cycle; the row of 32 restoring-division cells sets
// the depth. The whole pipeline holds while the output word waits.
// Reset (synchronous, active low) clears all valid bits and loads the
// coefficient reset values.
// ----------------------------------------------------------------------------
// biquad_power_response_trig_supplied_top
// Biquad power gain |B|^2/|A|^2 in Q16.16 from supplied trig values.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_power_response_trig_supplied_top (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire         [bprt_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire         [bprt_pkg::COEF_W-1:0]   i_cfg_data,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  signed [bprt_pkg::TRIG_W-1:0]   i_cos_w,
    input  wire  signed [bprt_pkg::TRIG_W-1:0]   i_sin_w,
    input  wire  signed [bprt_pkg::TRIG_W-1:0]   i_cos_2w,
    input  wire  signed [bprt_pkg::TRIG_W-1:0]   i_sin_2w,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic        [bprt_pkg::GAIN_W-1:0]   o_power_gain,
    output logic                                 o_saturated,
    output logic                                 o_denom_zero
);

    localparam int FRONT = 4;
    localparam int NC    = bprt_pkg::NCELLS;

    logic signed [bprt_pkg::COEF_W-1:0] r_nc0, r_nc1, r_nc2, r_dc0, r_dc1, r_dc2;
    logic [FRONT-1:0] r_vld;
    logic             r_out_valid;
    logic [bprt_pkg::GAIN_W-1:0] r_gain;
    logic r_sat, r_dz;
    logic adv;
    logic [bprt_pkg::POW_W-1:0] num_pow, den_pow;
    bprt_pkg::t_cell r_head, n_head;
    bprt_pkg::t_cell cells [NC+1];

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc0 <= bprt_pkg::COEF_ONE;
            r_nc1 <= '0;
            r_nc2 <= '0;
            r_dc0 <= bprt_pkg::COEF_ONE;
            r_dc1 <= '0;
            r_dc2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bprt_pkg::REG_NUM_C0: r_nc0 <= i_cfg_data;
                bprt_pkg::REG_NUM_C1: r_nc1 <= i_cfg_data;
                bprt_pkg::REG_NUM_C2: r_nc2 <= i_cfg_data;
                bprt_pkg::REG_DEN_C0: r_dc0 <= i_cfg_data;
                bprt_pkg::REG_DEN_C1: r_dc1 <= i_cfg_data;
                bprt_pkg::REG_DEN_C2: r_dc2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bprt_poly u_num (
        .i_clk(i_clk), .i_en(adv),
        .i_c0(r_nc0), .i_c1(r_nc1), .i_c2(r_nc2),
        .i_cos_w(i_cos_w), .i_sin_w(i_sin_w),
        .i_cos_2w(i_cos_2w), .i_sin_2w(i_sin_2w),
        .o_power(num_pow)
    );

    bprt_poly u_den (
        .i_clk(i_clk), .i_en(adv),
        .i_c0(r_dc0), .i_c1(r_dc1), .i_c2(r_dc2),
        .i_cos_w(i_cos_w), .i_sin_w(i_sin_w),
        .i_cos_2w(i_cos_2w), .i_sin_2w(i_sin_2w),
        .o_power(den_pow)
    );

    // remainder starts at num >> 16; low num bits feed the cells from the word
    always_comb begin
        n_head.valid = r_vld[FRONT-1];
        n_head.rem   = bprt_pkg::POW_W'(num_pow[bprt_pkg::POW_W-1:bprt_pkg::FRAC_W]);
        n_head.den   = den_pow;
        n_head.word  = {num_pow[bprt_pkg::FRAC_W-1:0], {bprt_pkg::FRAC_W{1'b0}}};
        n_head.dz    = den_pow == '0;
        n_head.sat   = (den_pow != '0)
                     && (bprt_pkg::POW_W'(num_pow[bprt_pkg::POW_W-1:bprt_pkg::FRAC_W])
                         >= den_pow);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_head.valid <= 1'b0;
        end else if (adv) begin
            r_vld  <= {r_vld[FRONT-2:0], i_in_valid};
            r_head <= n_head;
        end
    end

    assign cells[0] = r_head;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        bprt_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
            .i_cell(cells[g]), .o_cell(cells[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= cells[NC].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_gain <= (cells[NC].dz || cells[NC].sat) ? '1 : cells[NC].word;
            r_sat  <= cells[NC].sat;
            r_dz   <= cells[NC].dz;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_power_gain = r_gain;
    assign o_saturated  = r_sat;
    assign o_denom_zero = r_dz;

endmodule

`default_nettype wire
